### sv/sftd_pkg.sv
// Shared types, constants and functions of the spectrum downsampler.
`default_nettype none
package sftd_pkg;

   localparam int SampleWidth = 8;
   localparam int FactorWidth = 7;
   localparam int RowLenWidth = 13;
   localparam int ChanWidth   = 12;
   localparam int SumWidth    = 16;
   localparam int QuotWidth   = 8;

   // Largest row and largest averaging factor
   localparam int MaxChannels = 4096;
   localparam int MaxFactor   = 64;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FREQ_FACTOR = 2'd0,
      CSR_TIME_FACTOR = 2'd1,
      CSR_ROW_LENGTH  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   // Divider sequencer states
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FDIV,
      BK_READ,
      BK_TDIV_START,
      BK_TDIV,
      BK_OUT
   } bk_state_type;

   // One job handed from front to back: a finished frequency-group sum
   typedef struct packed {
      logic signed [SumWidth-1:0] sum;
      logic [ChanWidth-1:0]       channel;
      logic                       first_row;
      logic                       last_row;
      logic                       last_in_row;
   } job_type;

   // Clamp a factor register to the range 1 .. max
   function automatic logic [FactorWidth-1:0] clamp_factor(
      input logic [FactorWidth-1:0] f,
      input logic [FactorWidth-1:0] max_f
   );
      logic [FactorWidth-1:0] r;
      r = f;
      if (f == '0) r = FactorWidth'(1);
      else if (f > max_f) r = max_f;
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/sftd_divider.sv
// Sequential signed divider: (sum + div/2) / div, truncating toward zero.
`default_nettype none
module sftd_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [sftd_pkg::SumWidth-1:0]  sum,
   input  wire logic [sftd_pkg::FactorWidth-1:0]      divisor,
   output logic                                       done,
   output logic signed [sftd_pkg::SumWidth-1:0]       quotient
);
   import sftd_pkg::*;

   localparam int DW = SumWidth + 1;
   localparam int CW = $clog2(DW + 1);

   div_state_type           state_ff, state_in;
   logic [DW-1:0]           num_ff, num_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [FactorWidth-1:0]  div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic [CW-1:0]           cnt_ff, cnt_in;

   logic signed [DW-1:0]    biased;
   logic [DW-1:0]           shifted;
   logic [DW-1:0]           trial;
   logic [DW-1:0]           qmag;

   // Add half the divisor, split into sign and magnitude
   always_comb begin
      biased = DW'(sum) + DW'(divisor >> 1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (cnt_ff == CW'(DW - 1)) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // One restoring step per cycle
   always_comb begin
      shifted = {rem_ff[DW-2:0], num_ff[DW-1]};
      trial   = shifted - DW'(div_ff);
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      if (state_ff == DIV_IDLE && start) begin
         neg_in = biased[DW-1];
         num_in = biased[DW-1] ? DW'(-biased) : DW'(biased);
         rem_in = '0;
         div_in = divisor;
         cnt_in = '0;
      end else if (state_ff == DIV_RUN) begin
         if (!trial[DW-1]) begin
            rem_in = trial;
            num_in = {num_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Outputs
   always_comb begin
      qmag     = neg_ff ? (-num_ff) : num_ff;
      done     = (state_ff == DIV_DONE);
      quotient = SumWidth'(qmag);
   end

endmodule
`default_nettype wire

### sv/sftd_front.sv
// Front end: frequency grouping, channel and row counting, job issue.
`default_nettype none
module sftd_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [sftd_pkg::FactorWidth-1:0]      freq_factor,
   input  wire logic [sftd_pkg::FactorWidth-1:0]      time_factor,
   input  wire logic [sftd_pkg::RowLenWidth-1:0]      row_length,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [sftd_pkg::SampleWidth-1:0] req_sample,
   input  wire logic                                  req_block_start,
   output logic                                       job_valid,
   input  wire logic                                  job_full,
   output sftd_pkg::job_type                          job
);
   import sftd_pkg::*;

   logic signed [SumWidth-1:0]  fsum_ff, fsum_in;
   logic [FactorWidth-1:0]      fcnt_ff, fcnt_in;
   logic [RowLenWidth-1:0]      chan_ff, chan_in;
   logic [FactorWidth-1:0]      row_ff, row_in;

   logic                        accept;
   logic signed [SumWidth-1:0]  fsum_c;
   logic [FactorWidth-1:0]      fcnt_c;
   logic [RowLenWidth-1:0]      chan_c;
   logic [FactorWidth-1:0]      row_c;
   logic [RowLenWidth-1:0]      chan_next;
   logic [FactorWidth-1:0]      row_next;
   logic                        group_done;

   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;

   // Counter cleanup, then accumulate
   always_comb begin
      fsum_c = fsum_ff;
      fcnt_c = fcnt_ff;
      chan_c = chan_ff;
      row_c  = row_ff;
      if (req_block_start) begin
         fsum_c = '0;
         fcnt_c = '0;
         chan_c = '0;
         row_c  = '0;
      end
      if (fcnt_c >= freq_factor) begin
         fcnt_c = '0;
         fsum_c = '0;
      end
      if (chan_c >= row_length) chan_c = '0;
      if (row_c >= time_factor) row_c = '0;

      fsum_c     = fsum_c + SumWidth'(req_sample);
      fcnt_c     = fcnt_c + FactorWidth'(1);
      group_done = (fcnt_c >= freq_factor);

      chan_next = chan_c + RowLenWidth'(1);
      row_next  = row_c;
      if (chan_next >= row_length) begin
         chan_next = '0;
         row_next  = row_c + FactorWidth'(1);
         if (row_next >= time_factor) row_next = '0;
      end

      fsum_in = fsum_c;
      fcnt_in = fcnt_c;
      chan_in = chan_c;
      row_in  = row_c;
      if (group_done) begin
         fsum_in = '0;
         fcnt_in = '0;
         chan_in = chan_next;
         row_in  = row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsum_ff <= '0;
         fcnt_ff <= '0;
         chan_ff <= '0;
         row_ff  <= '0;
      end else if (accept) begin
         fsum_ff <= fsum_in;
         fcnt_ff <= fcnt_in;
         chan_ff <= chan_in;
         row_ff  <= row_in;
      end
   end

   // Job word toward the back end
   always_comb begin
      job_valid       = accept && group_done;
      job.sum         = fsum_c;
      job.channel     = ChanWidth'(chan_c);
      job.first_row   = (row_c == '0);
      job.last_row    = (row_c == time_factor - FactorWidth'(1));
      job.last_in_row = (chan_c == row_length - RowLenWidth'(1));
   end

endmodule
`default_nettype wire

### sv/sftd_queue.sv
// Small FIFO of jobs between the front and back ends.
`default_nettype none
module sftd_queue #(
   parameter int Depth = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire sftd_pkg::job_type push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              empty,
   output sftd_pkg::job_type pop_data
);
   import sftd_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   job_type           mem_ff [Depth];
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [AW:0]       cnt_ff, cnt_in;

   // Pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) wp_in = (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + AW'(1);
      if (pop)  rp_in = (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + AW'(1);
      if (push && !pop) cnt_in = cnt_ff + (AW+1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

   assign full     = (cnt_ff == (AW+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];

endmodule
`default_nettype wire

### sv/sftd_back.sv
// Back end: frequency divide, time accumulation memory, output divide.
`default_nettype none
module sftd_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [sftd_pkg::FactorWidth-1:0]  freq_factor,
   input  wire logic [sftd_pkg::FactorWidth-1:0]  time_factor,
   input  wire logic                              job_empty,
   input  wire sftd_pkg::job_type                 job,
   output logic                                   job_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [sftd_pkg::SampleWidth-1:0] rsp_averaged_value,
   output logic [sftd_pkg::ChanWidth-1:0]         rsp_channel_index,
   output logic                                   rsp_last_in_row
);
   import sftd_pkg::*;

   localparam int AW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

   logic signed [SumWidth-1:0]  tsum_mem [MaxChannels];
   logic signed [SumWidth-1:0]  rd_ff;
   bk_state_type                st_ff, st_in;
   job_type                     job_ff;
   logic signed [SumWidth-1:0]  val_ff;
   logic signed [SumWidth-1:0]  total;
   logic                        div_start;
   logic signed [SumWidth-1:0]  div_sum;
   logic [FactorWidth-1:0]      div_den;
   logic                        div_done;
   logic signed [SumWidth-1:0]  div_q;
   logic                        out_v_ff;
   logic [QuotWidth-1:0]        out_val_ff;
   logic [ChanWidth-1:0]        out_ch_ff;
   logic                        out_last_ff;
   logic [AW-1:0]               addr;

   assign addr = job_ff.channel[AW-1:0];

   // Shared divider for both averaging steps
   sftd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (div_sum),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE:       if (!job_empty) st_in = BK_FDIV;
         BK_FDIV:       if (div_done) st_in = BK_READ;
         BK_READ:       st_in = job_ff.last_row ? BK_TDIV_START : BK_IDLE;
         BK_TDIV_START: st_in = BK_TDIV;
         BK_TDIV:       if (div_done) st_in = BK_OUT;
         BK_OUT:        if (!out_v_ff) st_in = BK_IDLE;
         default:       st_in = BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      total     = job_ff.first_row ? val_ff : rd_ff + val_ff;
      job_pop   = (st_ff == BK_IDLE) && !job_empty;
      div_start = job_pop || (st_ff == BK_TDIV_START);
      div_sum   = job_pop ? job.sum : total;
      div_den   = job_pop ? freq_factor : time_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= BK_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == BK_TDIV && div_done) out_v_ff <= 1'b1;
         else if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
      end
      if (job_pop) job_ff <= job;
      if (st_ff == BK_FDIV && div_done) val_ff <= div_q;
      rd_ff <= tsum_mem[addr];
      if (st_ff == BK_READ) tsum_mem[addr] <= total;
      if (st_ff == BK_TDIV && div_done) begin
         out_val_ff  <= div_q[QuotWidth-1:0];
         out_ch_ff   <= job_ff.channel;
         out_last_ff <= job_ff.last_in_row;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_averaged_value = out_val_ff;
   assign rsp_channel_index  = out_ch_ff;
   assign rsp_last_in_row    = out_last_ff;

endmodule
`default_nettype wire

### sv/spectrum_freq_time_downsampler.sv
// Top level of the spectrum frequency/time downsampler.
`default_nettype none
// Boxcar decimator for a time-major stream of signed 8-bit samples. The front
// end takes one sample per cycle unless the job queue is full and sums
// freq_factor adjacent samples; each finished group goes through a four-entry
// job queue to the back end, which divides it (rounded, toward zero),
// accumulates it per channel in a 4096-entry memory and, on the last row of a
// time group, divides again and presents one word. The back end computes one
// quotient bit per cycle in a shared divider, both for the frequency divide
// of each group and when a word is produced, and takes the next job only when
// it is through with the last, so small freq_factor values stall the input
// while the queue is full. block_start clears the counters; unfinished groups
// are dropped. The user must write configuration only while idle; the block
// itself does not enforce this.
module spectrum_freq_time_downsampler (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic signed [sftd_pkg::SampleWidth-1:0]  req_sample,
   input  wire logic                                     req_block_start,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed [sftd_pkg::SampleWidth-1:0]       rsp_averaged_value,
   output logic [sftd_pkg::ChanWidth-1:0]                rsp_channel_index,
   output logic                                          rsp_last_in_row,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [1:0]                               csr_index,
   input  wire logic [31:0]                              csr_data
);
   import sftd_pkg::*;

   logic [FactorWidth-1:0]  ff_reg_ff, tf_reg_ff;
   logic [RowLenWidth-1:0]  rl_reg_ff;
   logic [FactorWidth-1:0]  ff_eff, tf_eff;
   logic [RowLenWidth-1:0]  rl_eff;
   logic                    push, full, pop, empty;
   job_type                 push_job, pop_job;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_reg_ff <= FactorWidth'(1);
         tf_reg_ff <= FactorWidth'(1);
         rl_reg_ff <= RowLenWidth'(1);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FREQ_FACTOR: ff_reg_ff <= csr_data[FactorWidth-1:0];
            CSR_TIME_FACTOR: tf_reg_ff <= csr_data[FactorWidth-1:0];
            CSR_ROW_LENGTH:  rl_reg_ff <= csr_data[RowLenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Effective limits
   always_comb begin
      ff_eff = clamp_factor(ff_reg_ff, FactorWidth'(MaxFactor));
      tf_eff = clamp_factor(tf_reg_ff, FactorWidth'(MaxFactor));
      rl_eff = rl_reg_ff;
      if (rl_reg_ff == '0) rl_eff = RowLenWidth'(1);
      else if (rl_reg_ff > RowLenWidth'(MaxChannels)) rl_eff = RowLenWidth'(MaxChannels);
   end

   sftd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .freq_factor     (ff_eff),
      .time_factor     (tf_eff),
      .row_length      (rl_eff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .job_valid       (push),
      .job_full        (full),
      .job             (push_job)
   );

   sftd_queue #(.Depth(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (pop_job)
   );

   sftd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .freq_factor        (ff_eff),
      .time_factor        (tf_eff),
      .job_empty          (empty),
      .job                (pop_job),
      .job_pop            (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_averaged_value (rsp_averaged_value),
      .rsp_channel_index  (rsp_channel_index),
      .rsp_last_in_row    (rsp_last_in_row)
   );

endmodule
`default_nettype wire

### dv/spectrum_freq_time_downsampler_test.sv
// Testbench for the spectrum frequency/time downsampler: scoreboard, stimulus and checks.
`timescale 1ns / 1ps
`default_nettype none

// Predicts the averaged words from accepted samples and checks them in order
class downsample_scoreboard;
   typedef struct packed {
      logic signed [7:0] value;
      logic [11:0]       channel;
      logic              last;
   } avg_word_type;

   avg_word_type pending[$];
   int        errors;
   int        freq_factor_reg, time_factor_reg, row_length_reg;
   int        freq_sum, freq_count, channel_pos, row_in_group;
   int        chan_sums[4096];

   function void reset_state();
      freq_factor_reg = 1; time_factor_reg = 1; row_length_reg = 1;
      freq_sum = 0; freq_count = 0; channel_pos = 0; row_in_group = 0;
      pending.delete();
      errors = 0;
   endfunction

   function void write_reg(sftd_pkg::csr_index_type idx, int data);
      case (idx)
         sftd_pkg::CSR_FREQ_FACTOR: freq_factor_reg = data & 'h7f;
         sftd_pkg::CSR_TIME_FACTOR: time_factor_reg = data & 'h7f;
         sftd_pkg::CSR_ROW_LENGTH:  row_length_reg = data & 'h1fff;
         default: ;
      endcase
   endfunction

   function int clamp(int f, int max_f);
      if (f == 0) return 1;
      if (f > max_f) return max_f;
      return f;
   endfunction

   // Rounded average, truncating toward zero like C division
   function int rounded_div(int s, int d);
      return (s + d / 2) / d;
   endfunction

   function void note_sample(logic signed [7:0] smp, logic blk);
      int ff, tf, rl, v, ch;
      avg_word_type w;
      ff = clamp(freq_factor_reg, 64);
      tf = clamp(time_factor_reg, 64);
      rl = clamp(row_length_reg, 4096);
      if (blk) begin
         freq_sum = 0; freq_count = 0; channel_pos = 0; row_in_group = 0;
      end
      if (freq_count >= ff) begin
         freq_count = 0; freq_sum = 0;
      end
      if (channel_pos >= rl) channel_pos = 0;
      if (row_in_group >= tf) row_in_group = 0;
      freq_sum += smp;
      freq_count++;
      if (freq_count < ff) return;
      v = rounded_div(freq_sum, ff);
      freq_sum = 0; freq_count = 0;
      ch = channel_pos;
      if (row_in_group == 0) chan_sums[ch] = v;
      else chan_sums[ch] += v;
      if (row_in_group == tf - 1) begin
         w.value = 8'(rounded_div(chan_sums[ch], tf));
         w.channel = 12'(ch);
         w.last = (ch == rl - 1);
         pending.push_back(w);
      end
      ch++;
      if (ch >= rl) begin
         ch = 0;
         row_in_group++;
         if (row_in_group >= tf) row_in_group = 0;
      end
      channel_pos = ch;
   endfunction

   function void check_word(logic signed [7:0] value, logic [11:0] channel, logic last);
      avg_word_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected word value=%0d channel=%0d last=%0b",
                  $time, value, channel, last);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
         $display("%0t: averaged_value expected %0d actual %0d", $time, e.value, value);
         errors++;
      end
      if (channel !== e.channel) begin
         $display("%0t: channel_index expected %0d actual %0d", $time, e.channel, channel);
         errors++;
      end
      if (last !== e.last) begin
         $display("%0t: last_in_row expected %0b actual %0b", $time, e.last, last);
         errors++;
      end
   endfunction
endclass

module spectrum_freq_time_downsampler_test;
   import sftd_pkg::*;

   localparam int WatchdogLimit = 200000;
   localparam int DrainCycles   = 200;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic signed [7:0] req_sample = '0;
   logic              req_block_start = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic signed [7:0] rsp_averaged_value;
   logic [11:0]       rsp_channel_index;
   logic              rsp_last_in_row;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [31:0]       csr_data = '0;

   downsample_scoreboard sb;
   bit  idle_enable = 1;
   int  idle_cycles;

   spectrum_freq_time_downsampler uut (.*);

   always #5 clock = ~clock;

   // Result side: random stall bursts, checks on accepted words
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (idle_enable && burst == 0 && $urandom_range(0, 9) == 0)
            burst = $urandom_range(1, 16);
         if (burst > 0) begin
            rsp_stall <= 1;
            burst--;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_averaged_value, rsp_channel_index, rsp_last_in_row);

   // Watchdog on cycles with no acceptance on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("spectrum_freq_time_downsampler_test: FAIL");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, int data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 0;
   endtask

   // Wait until every expected word arrived, then let the back end settle
   task automatic wait_quiet();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(int ff, int tf, int rl);
      wait_quiet();
      write_csr(CSR_FREQ_FACTOR, ff);
      write_csr(CSR_TIME_FACTOR, tf);
      write_csr(CSR_ROW_LENGTH, rl);
   endtask

   // Send one sample word, with an optional random gap before it
   task automatic send_sample(logic signed [7:0] smp, logic blk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= smp;
      req_block_start <= blk;
      do @(posedge clock); while (req_stall);
      sb.note_sample(smp, blk);
   endtask

   task automatic end_stream();
      req_valid <= 0;
      req_block_start <= 0;
   endtask

   function automatic logic signed [7:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return -8'sd128;
         1: return 8'sd127;
         default: return 8'($urandom);
      endcase
   endfunction

   // A block of whole time groups with random content, sometimes cut short
   task automatic send_block(int ff, int tf, int rl, output int count);
      int n;
      n = ff * tf * rl * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) send_sample(rand_sample(), i == 0);
      count = n;
   endtask

   initial begin
      int ff, tf, rl, sent, n_sent;
      sb = new();
      sb.reset_state();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default factors, extremes and block restarts
      for (int i = 0; i < 4; i++) send_sample(i[0] ? 8'sd127 : -8'sd128, i == 2);
      end_stream();
      configure(2, 2, 2);
      for (int i = 0; i < 8; i++) send_sample(i < 4 ? -8'sd128 : 8'sd127, i == 0);
      send_sample(-8'sd3, 0);
      send_sample(8'sd5, 1);   // block start drops partial groups
      for (int i = 0; i < 7; i++) send_sample(-8'sd1, 0);
      end_stream();
      // Zero factors behave as one, oversized ones as the maximum
      configure(0, 0, 0);
      send_sample(8'sd77, 1);
      send_sample(-8'sd77, 0);
      end_stream();
      configure(127, 127, 8191);
      for (int i = 0; i < 64; i++) send_sample(-8'sd128, i == 0);
      end_stream();
      // Unused index is ignored
      wait_quiet();
      write_csr(CSR_UNUSED, 5);
      // Mid-stream counter restart: shrink factors after a partial group
      configure(3, 2, 3);
      for (int i = 0; i < 10; i++) send_sample(rand_sample(), i == 0);
      end_stream();
      configure(1, 1, 2);
      for (int i = 0; i < 4; i++) send_sample(rand_sample(), 0);
      end_stream();

      // Random phases; mostly small sizes, occasionally the largest factor
      sent = 0;
      while (sent < 2000) begin
         if (sent > 1500) idle_enable = 0;
         ff = $urandom_range(0, 9) == 0 ? 64 : $urandom_range(1, 4);
         tf = $urandom_range(0, 9) == 0 ? 64 : $urandom_range(1, 4);
         rl = $urandom_range(0, 19) == 0 ? 4096 : $urandom_range(1, 6);
         if (ff * tf * rl > 256) rl = 1;
         if (ff * tf > 256) tf = 1;
         configure(ff, tf, rl);
         for (int b = 0; b < 2; b++) begin
            send_block(ff, tf, rl, n_sent);
            sent += n_sent;
         end
         // some raw noise without block structure
         repeat ($urandom_range(0, 6)) begin
            send_sample(rand_sample(), $urandom_range(0, 15) == 0);
            sent++;
         end
         end_stream();
      end

      wait_quiet();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("spectrum_freq_time_downsampler_test: PASS");
      else
         $display("spectrum_freq_time_downsampler_test: FAIL");
      $finish;
   end
endmodule

`default_nettype wire
